/* hw/rtl/hrp_pkg.sv */
package hrp_pkg;

  localparam int unsigned ValueBufferBytes = 64;
  localparam int unsigned StoreLimit       = ValueBufferBytes - 2;
  localparam int unsigned StoredW          = $clog2(ValueBufferBytes);

  localparam logic [31:0] CrcPoly        = 32'hEDB88320;
  localparam logic [31:0] HGet           = 32'h6b9c6cfa;
  localparam logic [31:0] HPost          = 32'h6c1f8139;
  localparam logic [31:0] HOptions       = 32'hef70049d;
  localparam logic [31:0] HHead          = 32'h91661b28;
  localparam logic [31:0] HPut           = 32'h3837cb5e;
  localparam logic [31:0] HDelete        = 32'hcaeabb01;
  localparam logic [31:0] HTrace         = 32'hc60f1711;
  localparam logic [31:0] HHttp10        = 32'h17ea47f0;
  localparam logic [31:0] HHttp11        = 32'h60ed7766;
  localparam logic [31:0] HCrlfCrlf      = 32'h8bc21544;
  localparam logic [31:0] HCrlf          = 32'h14a285ac;
  localparam logic [31:0] HConnection    = 32'h66aa70b6;
  localparam logic [31:0] HContentLength = 32'hd87452f2;
  localparam logic [31:0] HCookie        = 32'h8d4cbf50;

  localparam logic [7:0] ChNul   = 8'h00;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0a;
  localparam logic [7:0] ChVt    = 8'h0b;
  localparam logic [7:0] ChFf    = 8'h0c;
  localparam logic [7:0] ChCr    = 8'h0d;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChAmp   = 8'h26;
  localparam logic [7:0] ChPlus  = 8'h2b;
  localparam logic [7:0] ChMinus = 8'h2d;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChEqual = 8'h3d;
  localparam logic [7:0] ChQuery = 8'h3f;

  typedef enum logic [2:0] {
    StBusy   = 3'd0,
    StDone   = 3'd1,
    StError  = 3'd2,
    StParam  = 3'd3,
    StCookie = 3'd4
  } hrp_status_e;

  typedef enum logic [2:0] {
    MethUnknown = 3'd0,
    MethGet     = 3'd1,
    MethPost    = 3'd2,
    MethOptions = 3'd3,
    MethHead    = 3'd4,
    MethPut     = 3'd5,
    MethDelete  = 3'd6,
    MethTrace   = 3'd7
  } hrp_method_e;

  typedef enum logic [1:0] {
    VerUnknown = 2'd0,
    VerHttp10  = 2'd1,
    VerHttp11  = 2'd2
  } hrp_version_e;

  typedef struct packed {
    logic       command;
    logic [7:0] symbol;
  } hrp_item_t;

  typedef struct packed {
    hrp_status_e  status;
    logic [31:0]  token_hash;
    hrp_method_e  method;
    hrp_version_e version;
    logic [31:0]  resource_hash;
    logic         close_connection;
    logic [29:0]  content_length;
    logic [7:0]   value_byte;
    logic         value_valid;
  } hrp_result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] c;
    c = ~crc ^ {24'h000000, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return ~c;
  endfunction

  function automatic hrp_method_e method_of(input logic [31:0] h);
    hrp_method_e m;
    case (h)
      HGet:     m = MethGet;
      HPost:    m = MethPost;
      HOptions: m = MethOptions;
      HHead:    m = MethHead;
      HPut:     m = MethPut;
      HDelete:  m = MethDelete;
      HTrace:   m = MethTrace;
      default:  m = MethUnknown;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] close_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h63;
      3'd1:    ch = 8'h6c;
      3'd2:    ch = 8'h6f;
      3'd3:    ch = 8'h73;
      3'd4:    ch = 8'h65;
      default: ch = ChNul;
    endcase
    return ch;
  endfunction

endpackage

/* hw/rtl/hrp_in_stage.sv */
module hrp_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              ready_o,
  input  hrp_pkg::hrp_item_t item_i,
  input  logic              advance_i,
  output logic              step_o,
  output hrp_pkg::hrp_item_t item_o
);
  import hrp_pkg::*;

  logic      item_valid_q;
  hrp_item_t item_q;

  assign ready_o = !item_valid_q || advance_i;
  assign step_o  = item_valid_q && advance_i;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (ready_o) begin
      item_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

/* hw/rtl/hrp_core.sv */
module hrp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  hrp_pkg::hrp_item_t   item_i,
  output hrp_pkg::hrp_result_t result_o
);
  import hrp_pkg::*;

  typedef enum logic [3:0] {
    PhStart, PhMethod, PhPath, PhQname, PhQvalue, PhQnext, PhQend,
    PhProto, PhEol, PhCookie, PhHname, PhHvalue, PhDone, PhError
  } phase_e;

  typedef enum logic [1:0] {
    NumSpace, NumDigits, NumStop
  } num_e;

  typedef struct packed {
    logic [StoredW-1:0] stored;
    logic               ended;
    logic               in_spaces;
    logic [2:0]         match;
    logic               mismatch;
    logic [3:0]         rest;
    num_e               num_phase;
    logic               negative;
    logic [29:0]        acc;
  } scan_t;

  localparam logic [3:0] RestCap = 4'd10;
  localparam logic [2:0] CloseLen = 3'd5;

  phase_e       phase_q, phase_d, phase_eff;
  logic [31:0]  hash_q, hash_d, hash_eff;
  hrp_method_e  method_q, method_d;
  hrp_version_e version_q, version_d;
  logic [31:0]  path_q, path_d;
  logic         close_q, close_d;
  logic [29:0]  length_q, length_d;
  scan_t        scan_q, scan_d, scan_nx, scan_clr;

  logic [7:0]  sym;
  logic        is_cr, is_lf, is_sp, is_ws, is_sign, is_digit;
  logic [31:0] crc_run, crc_new, crc_path;
  logic [3:0]  rest_inc;
  logic        run_digits;
  logic        stored_val;
  hrp_status_e status;

  assign sym      = item_i.symbol;
  assign is_cr    = (sym == ChCr);
  assign is_lf    = (sym == ChLf);
  assign is_sp    = (sym == ChSpace);
  assign is_ws    = is_sp || (sym == ChTab) || (sym == ChVt) || (sym == ChFf);
  assign is_sign  = (sym == ChPlus) || (sym == ChMinus);
  assign is_digit = (sym >= ChZero) && (sym <= ChNine);

  always_comb begin
    phase_eff = phase_q;
    hash_eff  = hash_q;
    if (phase_q == PhQnext) begin
      phase_eff = PhQname;
      hash_eff  = '0;
    end else if (phase_q == PhQend) begin
      phase_eff = PhProto;
      hash_eff  = '0;
    end
  end

  assign crc_run  = crc_byte(hash_eff, sym);
  assign crc_new  = crc_byte('0, sym);
  assign crc_path = crc_byte(path_q, sym);

  always_comb begin
    scan_clr           = '0;
    scan_clr.in_spaces = 1'b1;
  end

  always_comb begin
    scan_nx    = scan_q;
    rest_inc   = (scan_q.rest < RestCap) ? scan_q.rest + 4'd1 : scan_q.rest;
    run_digits = 1'b0;
    if (!scan_q.ended && (scan_q.stored < StoredW'(StoreLimit))) begin
      scan_nx.stored = scan_q.stored + 1'b1;
      if (sym == ChNul) begin
        scan_nx.ended = 1'b1;
      end else if (!(scan_q.in_spaces && is_sp)) begin
        scan_nx.in_spaces = 1'b0;
        if ((scan_q.match < CloseLen) && (sym == close_char(scan_q.match))) begin
          scan_nx.match = scan_q.match + 3'd1;
        end else begin
          scan_nx.mismatch = 1'b1;
        end
        scan_nx.rest = rest_inc;
        if (rest_inc < RestCap) begin
          if (scan_q.num_phase == NumSpace) begin
            if (!is_ws) begin
              scan_nx.num_phase = NumDigits;
              if (is_sign) begin
                scan_nx.negative = (sym == ChMinus);
              end else begin
                run_digits = 1'b1;
              end
            end
          end else if (scan_q.num_phase == NumDigits) begin
            run_digits = 1'b1;
          end
          if (run_digits) begin
            if (is_digit) begin
              scan_nx.acc = {scan_q.acc[26:0], 3'b000} + {scan_q.acc[28:0], 1'b0}
                          + {26'd0, sym[3:0]};
            end else begin
              scan_nx.num_phase = NumStop;
            end
          end
        end
      end
    end
  end

  always_comb begin
    phase_d    = phase_q;
    hash_d     = hash_q;
    method_d   = method_q;
    version_d  = version_q;
    path_d     = path_q;
    close_d    = close_q;
    length_d   = length_q;
    scan_d     = scan_q;
    stored_val = 1'b0;
    if (step_i) begin
      if (item_i.command) begin
        phase_d = PhStart;
      end else begin
        phase_d = phase_eff;
        hash_d  = hash_eff;
        case (phase_eff)
          PhStart: begin
            if (!(is_cr || is_lf || is_sp)) begin
              method_d  = MethUnknown;
              version_d = VerUnknown;
              path_d    = '0;
              close_d   = 1'b0;
              length_d  = '0;
              hash_d    = crc_new;
              phase_d   = PhMethod;
            end
          end
          PhMethod: begin
            if (is_sp) begin
              method_d = method_of(hash_eff);
              path_d   = '0;
              phase_d  = PhPath;
            end else begin
              hash_d = crc_run;
            end
          end
          PhPath: begin
            if (sym == ChQuery) begin
              hash_d  = '0;
              phase_d = PhQname;
            end else if (is_sp) begin
              hash_d  = '0;
              phase_d = PhProto;
            end else begin
              path_d = crc_path;
            end
          end
          PhQname: begin
            if (sym == ChEqual) begin
              phase_d = PhQvalue;
            end else if (is_sp) begin
              phase_d = PhQend;
            end else begin
              hash_d = crc_run;
            end
          end
          PhQvalue: begin
            if (is_sp) begin
              phase_d = PhQend;
            end else if (sym == ChAmp) begin
              phase_d = PhQnext;
            end else begin
              stored_val = 1'b1;
            end
          end
          PhProto: begin
            if (is_cr) begin
              if (hash_eff == HHttp10) begin
                version_d = VerHttp10;
              end else if (hash_eff == HHttp11) begin
                version_d = VerHttp11;
              end else begin
                version_d = VerUnknown;
              end
              hash_d  = crc_new;
              phase_d = PhEol;
            end else begin
              hash_d = crc_run;
            end
          end
          PhEol, PhCookie: begin
            if (is_cr || is_lf) begin
              if (crc_run == HCrlfCrlf) begin
                hash_d  = '0;
                phase_d = PhDone;
              end else begin
                hash_d = crc_run;
              end
            end else if (hash_eff == HCrlf) begin
              hash_d  = crc_new;
              phase_d = PhHname;
            end else begin
              phase_d = PhError;
            end
          end
          PhHname: begin
            if (sym == ChColon) begin
              scan_d  = scan_clr;
              phase_d = PhHvalue;
            end else begin
              hash_d = crc_run;
            end
          end
          PhHvalue: begin
            if (is_cr || is_lf) begin
              if ((hash_eff == HConnection) && !scan_q.mismatch
                  && (scan_q.match == CloseLen)) begin
                close_d = 1'b1;
              end
              if ((hash_eff == HContentLength) && (scan_q.rest < RestCap)) begin
                length_d = scan_q.negative ? '0 : scan_q.acc;
              end
              phase_d = (hash_eff == HCookie) ? PhCookie : PhEol;
              hash_d  = crc_new;
            end else begin
              scan_d     = scan_nx;
              stored_val = 1'b1;
            end
          end
          PhDone, PhError: begin
          end
          default: begin
            phase_d = PhStart;
          end
        endcase
      end
    end
  end

  always_comb begin
    case (phase_d)
      PhDone:          status = StDone;
      PhError:         status = StError;
      PhQnext, PhQend: status = StParam;
      PhCookie:        status = StCookie;
      default:         status = StBusy;
    endcase
  end

  always_comb begin
    result_o.status           = status;
    result_o.token_hash       = hash_d;
    result_o.method           = method_d;
    result_o.version          = version_d;
    result_o.resource_hash    = path_d;
    result_o.close_connection = close_d;
    result_o.content_length   = length_d;
    result_o.value_byte       = stored_val ? sym : ChNul;
    result_o.value_valid      = stored_val;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhStart;
      hash_q    <= '0;
      method_q  <= MethUnknown;
      version_q <= VerUnknown;
      path_q    <= '0;
      close_q   <= 1'b0;
      length_q  <= '0;
      scan_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      hash_q    <= hash_d;
      method_q  <= method_d;
      version_q <= version_d;
      path_q    <= path_d;
      close_q   <= close_d;
      length_q  <= length_d;
      scan_q    <= scan_d;
    end
  end

endmodule

/* hw/rtl/hrp_out_stage.sv */
module hrp_out_stage (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  hrp_pkg::hrp_result_t result_i,
  output logic                advance_o,
  output logic                valid_o,
  input  logic                ready_i,
  output hrp_pkg::hrp_result_t result_o
);
  import hrp_pkg::*;

  logic        out_valid_q;
  hrp_result_t result_q;

  assign advance_o = !out_valid_q || ready_i;
  assign valid_o   = out_valid_q;
  assign result_o  = result_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step_i) begin
      out_valid_q <= 1'b1;
    end else if (ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      result_q <= result_i;
    end
  end

endmodule

/* hw/rtl/http_request_header_parser.sv */
// HTTP request header parser taking one byte per transfer and returning exactly one result
// transfer for each, at a sustained rate of one byte per clock cycle while out_ready_i is
// high; a byte goes through the input register, then the parse step with its three CRC-32
// byte updates into the result register, and in_ready_o falls only while a finished result
// waits on out_ready_i. Command 1 sends the parser back to looking for a new request without
// clearing the reported fields, cleared by a new request's first byte not CR, LF or space.
module http_request_header_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        command_i,
  input  logic [7:0]  symbol_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] token_hash_o,
  output logic [2:0]  method_o,
  output logic [1:0]  version_o,
  output logic [31:0] resource_hash_o,
  output logic        close_connection_o,
  output logic [29:0] content_length_o,
  output logic [7:0]  value_byte_o,
  output logic        value_valid_o
);
  import hrp_pkg::*;

  hrp_item_t   in_item, core_item;
  hrp_result_t core_result, out_result;
  logic        advance, step;

  assign in_item.command = command_i;
  assign in_item.symbol  = symbol_i;

  hrp_in_stage u_in_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (in_valid_i),
    .ready_o   (in_ready_o),
    .item_i    (in_item),
    .advance_i (advance),
    .step_o    (step),
    .item_o    (core_item)
  );

  hrp_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .item_i   (core_item),
    .result_o (core_result)
  );

  hrp_out_stage u_out_stage (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .result_i  (core_result),
    .advance_o (advance),
    .valid_o   (out_valid_o),
    .ready_i   (out_ready_i),
    .result_o  (out_result)
  );

  assign status_o           = out_result.status;
  assign token_hash_o       = out_result.token_hash;
  assign method_o           = out_result.method;
  assign version_o          = out_result.version;
  assign resource_hash_o    = out_result.resource_hash;
  assign close_connection_o = out_result.close_connection;
  assign content_length_o   = out_result.content_length;
  assign value_byte_o       = out_result.value_byte;
  assign value_valid_o      = out_result.value_valid;

endmodule

/* hw/rtl/hrp_checker.sv */
module hrp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        command_i,
  input logic [7:0]  symbol_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [2:0]  status_o,
  input logic [31:0] token_hash_o,
  input logic [2:0]  method_o,
  input logic [1:0]  version_o,
  input logic [31:0] resource_hash_o,
  input logic        close_connection_o,
  input logic [29:0] content_length_o,
  input logic [7:0]  value_byte_o,
  input logic        value_valid_o
);
  import hrp_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(token_hash_o) && $stable(value_byte_o))
    else $error("Stalled result changed before its transfer.");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o <= StCookie))
    else $error("Status code out of range.");

  a_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !value_valid_o |-> (value_byte_o == ChNul))
    else $error("Value byte not cleared without a stored character.");

  a_value_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && value_valid_o |-> (status_o == StBusy))
    else $error("Value character reported outside a value.");

endmodule

bind http_request_header_parser hrp_checker u_hrp_checker (.*);
